[hw/rtl/c3zp_pkg.sv]
// ----------------------------------------------------------------------------
// c3zp_pkg: shared types and constants for the 3x3 zero-padded convolution
// Field widths, register codes, reset values and the control types that
// pass between the convolution modules.
// ----------------------------------------------------------------------------
package c3zp_pkg;

  // Fixed field widths
  localparam int PIX_W     = 8;   // signed pixel / result
  localparam int SIZE_W    = 6;   // image_size register
  localparam int KERNEL_W  = 48;  // one kernel row register
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int MAX_DIM_DEF     = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  // Register reset values
  localparam logic [SIZE_W-1:0]   IMAGE_SIZE_RST = SIZE_W'(8);
  localparam logic [KERNEL_W-1:0] KERNEL_RST     = 48'h071C_071C_071C;
  localparam int                  MIN_DIM        = 2;

  // Saturation bounds of the result
  localparam int PIX_MAX = 127;
  localparam int PIX_MIN = -128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIZE    = 2'd0,
    CFG_KERNEL_TOP    = 2'd1,
    CFG_KERNEL_MID    = 2'd2,
    CFG_KERNEL_BOTTOM = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

  // Border masks of the window center, plus the end-of-frame mark
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } win_flags_t;

endpackage

[hw/rtl/c3zp_pix_if.sv]
// ----------------------------------------------------------------------------
// c3zp_pix_if: input pixel channel
// Valid/ready channel carrying one signed pixel per request.
// ----------------------------------------------------------------------------
interface c3zp_pix_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3zp_pkg::PIX_W-1:0]   pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

[hw/rtl/c3zp_res_if.sv]
// ----------------------------------------------------------------------------
// c3zp_res_if: result channel
// Valid/ready channel carrying one convolution result per request.
// ----------------------------------------------------------------------------
interface c3zp_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3zp_pkg::PIX_W-1:0]   conv_out;
  logic                                frame_last;

  modport source (output valid, output conv_out, output frame_last, input ready);
  modport sink   (input valid, input conv_out, input frame_last, output ready);
endinterface

[hw/rtl/c3zp_line_cell.sv]
// ----------------------------------------------------------------------------
// c3zp_line_cell: one pixel cell of a line delay chain
// Takes its neighbor's pixel on each push, or the chain input when it is
// the entry cell for the current image width.
// ----------------------------------------------------------------------------
module c3zp_line_cell (
  input  logic                              clk,
  input  logic                              push,
  input  logic                              inject,
  input  logic [c3zp_pkg::PIX_W-1:0]        inject_pix,
  input  logic [c3zp_pkg::PIX_W-1:0]        prev_pix,
  output logic [c3zp_pkg::PIX_W-1:0]        pix
);

  always_ff @(posedge clk) begin
    if (push) begin
      pix <= inject ? inject_pix : prev_pix;
    end
  end

endmodule

[hw/rtl/c3zp_line_buf.sv]
// ----------------------------------------------------------------------------
// c3zp_line_buf: variable-length line delay
// A chain of MAX_DIM cells; data enters at cell MAX_DIM-n so the last cell
// holds the pixel pushed n-1 pushes ago.
// ----------------------------------------------------------------------------
module c3zp_line_buf #(
  parameter int MAX_DIM = c3zp_pkg::MAX_DIM_DEF,
  parameter int NW      = $clog2(MAX_DIM + 1)
) (
  input  logic                              clk,
  input  logic                              push,
  input  logic [NW-1:0]                     n_eff,
  input  logic [c3zp_pkg::PIX_W-1:0]        din,
  output logic [c3zp_pkg::PIX_W-1:0]        dout
);

  logic [c3zp_pkg::PIX_W-1:0] cell_pix [MAX_DIM];

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
    localparam logic [NW-1:0] ENTRY_N = NW'(MAX_DIM - i);
    logic [c3zp_pkg::PIX_W-1:0] prev;

    if (i == 0) begin : g_head
      assign prev = din;
    end else begin : g_body
      assign prev = cell_pix[i-1];
    end

    c3zp_line_cell u_cell (
      .clk        (clk),
      .push       (push),
      .inject     (n_eff == ENTRY_N),
      .inject_pix (din),
      .prev_pix   (prev),
      .pix        (cell_pix[i])
    );
  end

  assign dout = cell_pix[MAX_DIM-1];

endmodule

[hw/rtl/c3zp_mac.sv]
// ----------------------------------------------------------------------------
// c3zp_mac: masked 3x3 multiply-accumulate with rounding and saturation
// Products, row sums, total, then round-half-away and clamp into the
// output register. All stages advance together on en.
// ----------------------------------------------------------------------------
module c3zp_mac #(
  parameter int WEIGHT_BITS = c3zp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   win_valid,
  input  c3zp_pkg::win_flags_t                   win_flags,
  input  logic signed [c3zp_pkg::PIX_W-1:0]      win [9],
  input  logic [c3zp_pkg::KERNEL_W-1:0]          kernel_top,
  input  logic [c3zp_pkg::KERNEL_W-1:0]          kernel_mid,
  input  logic [c3zp_pkg::KERNEL_W-1:0]          kernel_bottom,
  output logic                                   out_valid,
  output logic signed [c3zp_pkg::PIX_W-1:0]      conv_out,
  output logic                                   frame_last
);

  localparam int PW    = WEIGHT_BITS + c3zp_pkg::PIX_W;
  localparam int RW    = PW + 2;
  localparam int ACC_W = PW + 4;
  localparam int SHIFT = WEIGHT_BITS - 2;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (WEIGHT_BITS - 3);

  logic [c3zp_pkg::KERNEL_W-1:0]     krow [3];
  logic signed [WEIGHT_BITS-1:0]     wt   [9];
  logic signed [c3zp_pkg::PIX_W-1:0] pm   [9];
  logic signed [PW-1:0]              prod_next [9];
  logic signed [PW-1:0]              prod [9];
  logic signed [RW-1:0]              rsum [3];
  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W-1:0]           rnd;
  logic signed [ACC_W-1:0]           q;
  logic signed [c3zp_pkg::PIX_W-1:0] sat;
  logic                              v2, v3, v4;
  logic                              last2, last3, last4;

  assign krow[0] = kernel_top;
  assign krow[1] = kernel_mid;
  assign krow[2] = kernel_bottom;

  // Weights and zero-padding masks; left weight sits in the high slot
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        wt[p*3+k] = krow[p][(2-k)*WEIGHT_BITS +: WEIGHT_BITS];
        if ((p == 0 && win_flags.top) || (p == 2 && win_flags.bottom) ||
            (k == 0 && win_flags.left) || (k == 2 && win_flags.right)) begin
          pm[p*3+k] = '0;
        end else begin
          pm[p*3+k] = win[p*3+k];
        end
        prod_next[p*3+k] = wt[p*3+k] * pm[p*3+k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= prod_next;
      last2 <= win_flags.last;
      for (int p = 0; p < 3; p++) begin
        rsum[p] <= RW'(prod[p*3]) + RW'(prod[p*3+1]) + RW'(prod[p*3+2]);
      end
      last3 <= last2;
      acc   <= ACC_W'(rsum[0]) + ACC_W'(rsum[1]) + ACC_W'(rsum[2]);
      last4 <= last3;
      conv_out   <= sat;
      frame_last <= last4;
    end
  end

  // Half away from zero: negative sums lose one before the floor shift
  always_comb begin
    rnd = acc + RND_HALF - {{(ACC_W-1){1'b0}}, acc[ACC_W-1]};
    q   = rnd >>> SHIFT;
    if (q > c3zp_pkg::PIX_MAX) begin
      sat = c3zp_pkg::PIX_W'(c3zp_pkg::PIX_MAX);
    end else if (q < c3zp_pkg::PIX_MIN) begin
      sat = c3zp_pkg::PIX_W'(c3zp_pkg::PIX_MIN);
    end else begin
      sat = q[c3zp_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2        <= win_valid;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule

[hw/rtl/conv3x3_zero_pad_unit.sv]
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_unit: streaming 3x3 "same" convolution, zero padded
// Raster-order signed pixels in, rounded and saturated Q2.14-weighted
// 3x3 sums out, same image size, last result of a frame marked.
// ----------------------------------------------------------------------------
//
//   port      dir  payload                      request moves
//   --------  ---  ---------------------------  --------------------------
//   pixels    in   pixel (s8)                   one raster-order pixel
//   results   out  conv_out (s8), frame_last    one output pixel
//   cfg_*     in   cfg_index, cfg_data (48b)    one register write
//
// Cycles: one pixel per cycle while results drain; results appear n+1
//   pixels after their center pixel, passing the products, row sums,
//   total and output registers after the push that forms the window.
// After the last pixel of a frame the input stalls for n+1 pushes, held
//   longer by output stalls, while zeros are pushed through the line delays.
// Stalls: the whole pipe advances only when the output register is empty
//   or being taken; a waiting result with results.ready low freezes it and
//   pixels.ready drops.
// Reset: synchronous; clears control state and loads register defaults.
//   Line delay contents are never cleared: border masks hide stale data.
//
module conv3x3_zero_pad_unit #(
  parameter int MAX_DIM     = c3zp_pkg::MAX_DIM_DEF,
  parameter int WEIGHT_BITS = c3zp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  c3zp_pix_if.sink                            pixels,
  c3zp_res_if.source                          results,
  input  logic                                cfg_we,
  input  logic [c3zp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c3zp_pkg::KERNEL_W-1:0]       cfg_data
);

  localparam int NW = $clog2(MAX_DIM + 1);   // holds the image size n
  localparam int CW = $clog2(MAX_DIM);       // holds a row/column index

  // Config registers
  logic [c3zp_pkg::SIZE_W-1:0]   image_size;
  logic [c3zp_pkg::KERNEL_W-1:0] kernel_top;
  logic [c3zp_pkg::KERNEL_W-1:0] kernel_mid;
  logic [c3zp_pkg::KERNEL_W-1:0] kernel_bottom;
  logic                          size_write;

  // Effective size, clamped to [2, MAX_DIM]
  logic [c3zp_pkg::SIZE_W-1:0]   size_clamped;
  logic [NW-1:0]                 n_eff;
  logic [NW-1:0]                 n_last;

  // Position of the next input pixel and of the next window center
  logic [CW-1:0]                 row_cnt, col_cnt;
  logic [CW-1:0]                 ctr_row, ctr_col;
  logic                          in_col_last, in_last;
  logic                          ctr_row_last, ctr_col_last, ctr_last;

  c3zp_pkg::state_t              state, state_next;

  // Handshake and push control
  logic                          en;
  logic                          accept;
  logic                          flush_push;
  logic                          push;
  logic                          emit;
  logic [c3zp_pkg::PIX_W-1:0]    push_pix;

  // Line delays and the 3x3 window; index 0 is the newest (right) column
  logic [c3zp_pkg::PIX_W-1:0]         line1_out, line2_out;
  logic signed [c3zp_pkg::PIX_W-1:0]  win_t [3];
  logic signed [c3zp_pkg::PIX_W-1:0]  win_m [3];
  logic signed [c3zp_pkg::PIX_W-1:0]  win_b [3];
  logic signed [c3zp_pkg::PIX_W-1:0]  win   [9];
  logic                               win_valid;
  c3zp_pkg::win_flags_t               win_flags;
  logic                               mac_valid;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign size_write = cfg_we &&
                      (c3zp_pkg::cfg_index_t'(cfg_index) == c3zp_pkg::CFG_IMAGE_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size    <= c3zp_pkg::IMAGE_SIZE_RST;
      kernel_top    <= c3zp_pkg::KERNEL_RST;
      kernel_mid    <= c3zp_pkg::KERNEL_RST;
      kernel_bottom <= c3zp_pkg::KERNEL_RST;
    end else if (cfg_we) begin
      case (c3zp_pkg::cfg_index_t'(cfg_index))
        c3zp_pkg::CFG_IMAGE_SIZE:    image_size    <= cfg_data[c3zp_pkg::SIZE_W-1:0];
        c3zp_pkg::CFG_KERNEL_TOP:    kernel_top    <= cfg_data;
        c3zp_pkg::CFG_KERNEL_MID:    kernel_mid    <= cfg_data;
        c3zp_pkg::CFG_KERNEL_BOTTOM: kernel_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_size < c3zp_pkg::SIZE_W'(c3zp_pkg::MIN_DIM)) begin
      size_clamped = c3zp_pkg::SIZE_W'(c3zp_pkg::MIN_DIM);
    end else if (image_size > c3zp_pkg::SIZE_W'(MAX_DIM)) begin
      size_clamped = c3zp_pkg::SIZE_W'(MAX_DIM);
    end else begin
      size_clamped = image_size;
    end
  end

  assign n_eff  = NW'(size_clamped);
  assign n_last = n_eff - NW'(1);

  // --------------------------------------------------------------------------
  // Position tracking
  // --------------------------------------------------------------------------
  assign in_col_last  = (NW'(col_cnt) == n_last);
  assign in_last      = in_col_last && (NW'(row_cnt) == n_last);
  assign ctr_col_last = (NW'(ctr_col) == n_last);
  assign ctr_row_last = (NW'(ctr_row) == n_last);
  assign ctr_last     = ctr_col_last && ctr_row_last;

  // --------------------------------------------------------------------------
  // Flush state machine
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      c3zp_pkg::ST_RUN: begin
        if (accept && in_last) state_next = c3zp_pkg::ST_FLUSH;
      end
      c3zp_pkg::ST_FLUSH: begin
        if (flush_push && ctr_last) state_next = c3zp_pkg::ST_RUN;
      end
      default: state_next = c3zp_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    pixels.ready = 1'b0;
    flush_push   = 1'b0;
    case (state)
      c3zp_pkg::ST_RUN:   pixels.ready = en;
      c3zp_pkg::ST_FLUSH: flush_push   = en;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      state <= c3zp_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Pipe advances when the output register is free or being taken
  assign en     = !mac_valid || results.ready;
  assign accept = pixels.valid && pixels.ready;
  assign push   = accept || flush_push;

  // Flush pushes zeros; they fall under the bottom or right mask anyway
  assign push_pix = accept ? pixels.pixel : '0;

  // A result is due once n+1 pixels of the frame are in, and on every flush
  assign emit = flush_push ||
                (accept && ((row_cnt >= CW'(2)) ||
                            ((row_cnt == CW'(1)) && (col_cnt != '0))));

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      row_cnt <= '0;
      col_cnt <= '0;
      ctr_row <= '0;
      ctr_col <= '0;
    end else begin
      if (accept) begin
        if (in_last) begin
          row_cnt <= '0;
          col_cnt <= '0;
        end else if (in_col_last) begin
          row_cnt <= row_cnt + CW'(1);
          col_cnt <= '0;
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
      end
      if (emit) begin
        if (ctr_last) begin
          ctr_row <= '0;
          ctr_col <= '0;
        end else if (ctr_col_last) begin
          ctr_row <= ctr_row + CW'(1);
          ctr_col <= '0;
        end else begin
          ctr_col <= ctr_col + CW'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line delays: line1 out is n-1 pushes old, line2 out 2n-1
  // --------------------------------------------------------------------------
  c3zp_line_buf #(
    .MAX_DIM (MAX_DIM),
    .NW      (NW)
  ) u_line1 (
    .clk   (clk),
    .push  (push),
    .n_eff (n_eff),
    .din   (push_pix),
    .dout  (line1_out)
  );

  c3zp_line_buf #(
    .MAX_DIM (MAX_DIM),
    .NW      (NW)
  ) u_line2 (
    .clk   (clk),
    .push  (push),
    .n_eff (n_eff),
    .din   (line1_out),
    .dout  (line2_out)
  );

  // --------------------------------------------------------------------------
  // Window: bottom row newest; center is win_m[1], n+1 pushes old
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (push) begin
      win_b[0] <= push_pix;
      win_m[0] <= line1_out;
      win_t[0] <= line2_out;
      for (int i = 1; i < 3; i++) begin
        win_b[i] <= win_b[i-1];
        win_m[i] <= win_m[i-1];
        win_t[i] <= win_t[i-1];
      end
    end
    if (push && emit) begin
      win_flags.top    <= (ctr_row == '0);
      win_flags.bottom <= ctr_row_last;
      win_flags.left   <= (ctr_col == '0);
      win_flags.right  <= ctr_col_last;
      win_flags.last   <= ctr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (en) begin
      win_valid <= push && emit;
    end
  end

  // Row-major, left column first, to match the kernel layout
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win[k]     = win_t[2-k];
      win[3 + k] = win_m[2-k];
      win[6 + k] = win_b[2-k];
    end
  end

  // --------------------------------------------------------------------------
  // Multiply-accumulate, round, saturate, output register
  // --------------------------------------------------------------------------
  c3zp_mac #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_mac (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .win_valid     (win_valid),
    .win_flags     (win_flags),
    .win           (win),
    .kernel_top    (kernel_top),
    .kernel_mid    (kernel_mid),
    .kernel_bottom (kernel_bottom),
    .out_valid     (mac_valid),
    .conv_out      (results.conv_out),
    .frame_last    (results.frame_last)
  );

  assign results.valid = mac_valid;

endmodule
